### design/carriage_position_tracker_top_assert.svh
// Assertion macros for the carriage position tracker.
`ifndef CARRIAGE_POSITION_TRACKER_TOP_ASSERT_SVH
`define CARRIAGE_POSITION_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("carriage position tracker: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("carriage position tracker: next-cycle check failed");

`endif

### design/cpt_pkg.sv
// Package with the types, codes and lookup functions of the carriage position tracker.
`default_nettype none

package cpt_pkg;

    localparam logic [1:0] OP_RESET    = 2'd0;
    localparam logic [1:0] OP_SET_POS  = 2'd1;
    localparam logic [1:0] OP_CROSSING = 2'd2;
    localparam logic [1:0] OP_WORK     = 2'd3;

    localparam logic [2:0] TYPE_NONE   = 3'd0;
    localparam logic [2:0] TYPE_KNIT   = 3'd1;
    localparam logic [2:0] TYPE_LACE   = 3'd2;
    localparam logic [2:0] TYPE_GARTER = 3'd3;
    localparam logic [2:0] TYPE_K270   = 3'd4;

    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    localparam logic DIR_LEFT  = 1'b0;
    localparam logic DIR_RIGHT = 1'b1;

    // Inner-magnet corrections.
    localparam logic [15:0] GARTER_CORRECTION = 16'd12;
    localparam logic [15:0] K270_CORRECTION   = 16'd6;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] new_position;
        logic signed [15:0] detected_position;
        logic [7:0]         sensor_location;
        logic [2:0]         detected_type;
        logic               direction;
        logic [1:0]         work_side;
    } cpt_in_t;

    typedef struct packed {
        logic               crossed;
        logic               finished;
        logic               defined;
        logic [2:0]         carriage_type;
        logic signed [15:0] carriage_position;
        logic signed [15:0] select_when_left;
        logic signed [15:0] select_when_right;
        logic               working;
    } cpt_out_t;

    typedef struct packed {
        logic [2:0]  carriage_type;
        logic [15:0] position;
        logic        working;
        logic [1:0]  entry_side;
        logic [7:0]  overflow;
    } cpt_state_t;

    // Countdown length loaded when a work window opens.
    function automatic logic [7:0] extension(input logic [2:0] ctype);
        logic [7:0] ext;
        case (ctype)
            TYPE_GARTER: ext = 8'd18;
            TYPE_K270:   ext = 8'd8;
            default:     ext = 8'd12;
        endcase
        return ext;
    endfunction

    // Select offset for leftward travel; rightward travel uses its negation.
    function automatic logic [15:0] select_offset(input logic [2:0] ctype);
        logic [15:0] offl;
        case (ctype)
            TYPE_GARTER: offl = 16'hFFF8;
            TYPE_LACE:   offl = 16'd4;
            TYPE_K270:   offl = 16'd6;
            default:     offl = 16'd16;
        endcase
        return offl;
    endfunction

endpackage

`default_nettype wire

### design/cpt_stream_if.sv
// Valid/ready stream interface that carries one payload beat per handshake.
`default_nettype none

interface cpt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/cpt_update.sv
// Next-state and result logic for one item of the carriage position tracker.
`default_nettype none

module cpt_update
    import cpt_pkg::*;
(
    input  cpt_state_t state,
    input  cpt_in_t    item,
    output cpt_state_t state_next,
    output cpt_out_t   result
);

    logic [15:0] offset;
    logic        cross_dir;
    logic [15:0] cross_base;
    logic [7:0]  count;
    logic        crossed;
    logic        finished;
    logic [15:0] offl;

    assign offset     = state.position - $unsigned(item.detected_position);
    assign cross_dir  = (offset != 16'd0) && !offset[15];
    assign cross_base = {8'd0, item.sensor_location} + offset;

    always_comb
    begin
        state_next = state;
        crossed    = 1'b0;
        finished   = 1'b0;
        count      = state.overflow;
        case (item.opcode)
            OP_RESET:
            begin
                state_next.carriage_type = TYPE_NONE;
                state_next.position      = 16'd0;
                state_next.working       = 1'b0;
                state_next.entry_side    = SIDE_NONE;
            end
            OP_SET_POS:
            begin
                state_next.position = $unsigned(item.new_position);
            end
            OP_CROSSING:
            begin
                if ((cross_dir == item.direction) && (state.carriage_type != TYPE_K270))
                begin
                    crossed                  = 1'b1;
                    state_next.carriage_type = item.detected_type;
                    state_next.working       = 1'b0;
                    state_next.entry_side    = SIDE_NONE;
                    state_next.position      = cross_base;
                    if (item.detected_type == TYPE_GARTER)
                    begin
                        state_next.position = cross_dir ? cross_base - GARTER_CORRECTION
                                                        : cross_base + GARTER_CORRECTION;
                    end
                    else if (item.detected_type == TYPE_K270)
                    begin
                        state_next.position = cross_dir ? cross_base - K270_CORRECTION
                                                        : cross_base + K270_CORRECTION;
                    end
                end
            end
            OP_WORK:
            begin
                if (state.working)
                begin
                    if ((state.entry_side == SIDE_LEFT) && (item.work_side == SIDE_RIGHT))
                    begin
                        count = (item.direction == DIR_RIGHT) ? state.overflow - 8'd1
                                                              : state.overflow + 8'd1;
                    end
                    else if ((state.entry_side == SIDE_RIGHT) && (item.work_side == SIDE_LEFT))
                    begin
                        count = (item.direction == DIR_LEFT) ? state.overflow - 8'd1
                                                             : state.overflow + 8'd1;
                    end
                    state_next.overflow = count;
                    if (count == 8'd0)
                    begin
                        finished              = 1'b1;
                        state_next.working    = 1'b0;
                        state_next.entry_side = SIDE_NONE;
                    end
                end
                else if (item.work_side == SIDE_NONE)
                begin
                    if (state.entry_side == SIDE_NONE)
                    begin
                        state_next.entry_side = (item.direction == DIR_RIGHT) ? SIDE_LEFT
                                                                              : SIDE_RIGHT;
                    end
                    state_next.overflow = extension(state.carriage_type);
                    state_next.working  = 1'b1;
                end
                else
                begin
                    state_next.entry_side = item.work_side;
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    assign offl = select_offset(state_next.carriage_type);

    always_comb
    begin
        result.crossed           = crossed;
        result.finished          = finished;
        result.defined           = (state_next.carriage_type != TYPE_NONE);
        result.carriage_type     = state_next.carriage_type;
        result.carriage_position = $signed(state_next.position);
        result.select_when_left  = $signed(state_next.position + offl);
        result.select_when_right = $signed(state_next.position - offl);
        result.working           = state_next.working;
    end

endmodule

`default_nettype wire

### design/carriage_position_tracker_top.sv
// Top level of the carriage position tracker: input register, update logic, result register.
//
// Usage:
// The in_ch channel takes one beat per command: reset, set position, sensor
// crossing or work step, with the sensor and direction fields that go with it.
// The out_ch channel returns exactly one beat per command, in order, giving the
// carriage type, position, select positions and work window after the update.
// A beat accepted on in_ch lands in the input register; once the result register
// can take a beat, the update logic applies it to the tracking state and loads
// the result register, so each result passes through both registers.
// Throughput is one beat per cycle while out_ch does not stall; the update path is combinational.
// When the receiver stalls, the result register holds its beat and the input
// register holds one more; in_ch.ready then drops until out_ch moves again.
// Reset empties both pipeline registers and returns the tracking state to no
// carriage, position zero, outside any work window, countdown zero.
`default_nettype none

module carriage_position_tracker_top
    import cpt_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    cpt_stream_if.sink   in_ch,
    cpt_stream_if.source out_ch
);

    `include "carriage_position_tracker_top_assert.svh"

    cpt_in_t    in_data_reg;
    logic       in_valid_reg;
    cpt_out_t   out_data_reg;
    logic       out_valid_reg;
    cpt_state_t state_reg;
    cpt_state_t state_next;
    cpt_out_t   result;
    logic       advance;
    logic       in_take;

    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;
    assign in_take      = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    cpt_update u_update (
        .state      (state_reg),
        .item       (in_data_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{carriage_type: TYPE_NONE, position: 16'd0, working: 1'b0,
                               entry_side: SIDE_NONE, overflow: 8'd0};
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= in_ch.data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    `CPT_ASSERT_NOW(a_finish_closes_window, out_ch.valid && out_ch.data.finished, !out_ch.data.working)
    `CPT_ASSERT_NOW(a_cross_finish_excl, out_ch.valid, !(out_ch.data.crossed && out_ch.data.finished))
    `CPT_ASSERT_NEXT(a_advance_loads_out, advance, out_ch.valid)
    `CPT_ASSERT_NOW(a_stall_source, !in_ch.ready, in_valid_reg && out_ch.valid && !out_ch.ready)

endmodule

`default_nettype wire

### tb/sv/tb_carriage_position_tracker_top.sv
// Self-checking testbench for the carriage position tracker: directed and random command beats.
module tb_carriage_position_tracker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cpt_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 1320;

    logic clk = 1'b0;
    logic rst_n;

    cpt_stream_if #(.payload_t(cpt_in_t))  in_ch ();
    cpt_stream_if #(.payload_t(cpt_out_t)) out_ch ();

    carriage_position_tracker_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    cpt_state_t  tracker = '0;
    cpt_out_t    expected_results[$];
    int          mismatches = 0;
    int unsigned cycles = 0;
    bit          steady = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ch.ready <= steady || ($urandom_range(99) >= 38);
    end

    function automatic void clear_tracking();
        tracker.carriage_type = TYPE_NONE;
        tracker.position      = 16'd0;
        tracker.working       = 1'b0;
        tracker.entry_side    = SIDE_NONE;
    endfunction

    function automatic cpt_out_t apply_command(input cpt_in_t cmd);
        cpt_out_t    res;
        logic [15:0] offset;
        logic [15:0] shift;
        logic        travel_right;
        res = '0;
        case (cmd.opcode)
            OP_RESET:
                clear_tracking();
            OP_SET_POS:
                tracker.position = cmd.new_position;
            OP_CROSSING:
            begin
                offset       = tracker.position - cmd.detected_position;
                travel_right = (offset != 16'd0) && !offset[15];
                if (travel_right == cmd.direction && tracker.carriage_type != TYPE_K270)
                begin
                    clear_tracking();
                    tracker.carriage_type = cmd.detected_type;
                    tracker.position      = {8'd0, cmd.sensor_location} + offset;
                    if (cmd.detected_type == TYPE_GARTER)
                        tracker.position = travel_right ? tracker.position - GARTER_CORRECTION
                                                        : tracker.position + GARTER_CORRECTION;
                    else if (cmd.detected_type == TYPE_K270)
                        tracker.position = travel_right ? tracker.position - K270_CORRECTION
                                                        : tracker.position + K270_CORRECTION;
                    res.crossed = 1'b1;
                end
            end
            default:
            begin
                if (tracker.working)
                begin
                    if (tracker.entry_side == SIDE_LEFT && cmd.work_side == SIDE_RIGHT)
                        tracker.overflow = (cmd.direction == DIR_RIGHT) ? tracker.overflow - 8'd1
                                                                        : tracker.overflow + 8'd1;
                    else if (tracker.entry_side == SIDE_RIGHT && cmd.work_side == SIDE_LEFT)
                        tracker.overflow = (cmd.direction == DIR_LEFT) ? tracker.overflow - 8'd1
                                                                       : tracker.overflow + 8'd1;
                    if (tracker.overflow == 8'd0)
                    begin
                        res.finished       = 1'b1;
                        tracker.working    = 1'b0;
                        tracker.entry_side = SIDE_NONE;
                    end
                end
                else if (cmd.work_side == SIDE_NONE)
                begin
                    if (tracker.entry_side == SIDE_NONE)
                        tracker.entry_side = (cmd.direction == DIR_RIGHT) ? SIDE_LEFT : SIDE_RIGHT;
                    case (tracker.carriage_type)
                        TYPE_GARTER: tracker.overflow = 8'd18;
                        TYPE_K270:   tracker.overflow = 8'd8;
                        default:     tracker.overflow = 8'd12;
                    endcase
                    tracker.working = 1'b1;
                end
                else
                begin
                    tracker.entry_side = cmd.work_side;
                end
            end
        endcase

        case (tracker.carriage_type)
            TYPE_GARTER: shift = 16'hFFF8;
            TYPE_LACE:   shift = 16'd4;
            TYPE_K270:   shift = 16'd6;
            default:     shift = 16'd16;
        endcase
        res.defined           = (tracker.carriage_type != TYPE_NONE);
        res.carriage_type     = tracker.carriage_type;
        res.carriage_position = tracker.position;
        res.select_when_left  = tracker.position + shift;
        res.select_when_right = tracker.position - shift;
        res.working           = tracker.working;
        return res;
    endfunction

    function automatic cpt_in_t make_cmd(input logic [1:0] op, input logic [15:0] newpos,
                                         input logic [15:0] detpos, input logic [7:0] loc,
                                         input logic [2:0] dtype, input logic dir,
                                         input logic [1:0] side);
        cpt_in_t cmd;
        cmd.opcode            = op;
        cmd.new_position      = newpos;
        cmd.detected_position = detpos;
        cmd.sensor_location   = loc;
        cmd.detected_type     = dtype;
        cmd.direction         = dir;
        cmd.work_side         = side;
        return cmd;
    endfunction

    function automatic cpt_in_t random_command();
        cpt_in_t     cmd;
        logic [15:0] gap;
        int unsigned pick;
        cmd = make_cmd(OP_RESET, 16'($urandom), 16'($urandom), 8'($urandom),
                       3'($urandom_range(0, 7)), 1'($urandom_range(1)),
                       2'($urandom_range(0, 3)));
        pick = $urandom_range(99);
        if (pick < 4)
        begin
            cmd.opcode = OP_RESET;
        end
        else if (pick < 16)
        begin
            cmd.opcode = OP_SET_POS;
            if ($urandom_range(1))
                cmd.new_position = 16'($urandom_range(0, 300));
        end
        else if (pick < 46)
        begin
            cmd.opcode = OP_CROSSING;
            if ($urandom_range(9) != 0)
                cmd.detected_type = 3'($urandom_range(0, 4));
            if ($urandom_range(99) < 75)
            begin
                gap = 16'($urandom_range(0, 40));
                cmd.detected_position = cmd.direction ? tracker.position - gap
                                                      : tracker.position + gap;
                if (gap == 16'd0)
                    cmd.direction = DIR_LEFT;
            end
        end
        else
        begin
            cmd.opcode = OP_WORK;
            if (tracker.working && $urandom_range(99) < 80)
            begin
                cmd.work_side = (tracker.entry_side == SIDE_LEFT) ? SIDE_RIGHT : SIDE_LEFT;
                if ($urandom_range(99) < 85)
                    cmd.direction = (tracker.entry_side == SIDE_LEFT) ? DIR_RIGHT : DIR_LEFT;
            end
            else if (!tracker.working && $urandom_range(99) < 60)
            begin
                cmd.work_side = SIDE_NONE;
            end
        end
        return cmd;
    endfunction

    task automatic push_command(input cpt_in_t cmd);
        while (!steady && $urandom_range(99) < 38)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= cmd;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_results.push_back(apply_command(cmd));
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        cpt_out_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with no command waiting");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("crossed", want.crossed, out_ch.data.crossed);
                check_field("finished", want.finished, out_ch.data.finished);
                check_field("defined", want.defined, out_ch.data.defined);
                check_field("carriage_type", want.carriage_type, out_ch.data.carriage_type);
                check_field("carriage_position", want.carriage_position,
                            out_ch.data.carriage_position);
                check_field("select_when_left", want.select_when_left,
                            out_ch.data.select_when_left);
                check_field("select_when_right", want.select_when_right,
                            out_ch.data.select_when_right);
                check_field("working", want.working, out_ch.data.working);
            end
        end
    end

    task automatic test_reset_and_position();
        push_command(make_cmd(OP_SET_POS, 16'h7FFF, 16'h0000, 8'd0, TYPE_NONE, DIR_LEFT, SIDE_NONE));
        push_command(make_cmd(OP_SET_POS, 16'h8000, 16'hFFFF, 8'd255, 3'd7, DIR_RIGHT, 2'd3));
        push_command(make_cmd(OP_SET_POS, 16'hFFFF, 16'h8000, 8'd1, TYPE_KNIT, DIR_LEFT, SIDE_LEFT));
        push_command(make_cmd(OP_RESET, 16'h1234, 16'h7FFF, 8'd128, TYPE_LACE, DIR_RIGHT, SIDE_RIGHT));
        push_command(make_cmd(OP_SET_POS, 16'd100, 16'd0, 8'd0, TYPE_NONE, DIR_LEFT, SIDE_NONE));
    endtask

    task automatic test_crossings();
        push_command(make_cmd(OP_CROSSING, 16'd0, 16'd100, 8'd0, TYPE_KNIT, DIR_LEFT, SIDE_NONE));
        push_command(make_cmd(OP_SET_POS, 16'd50, 16'd0, 8'd0, TYPE_NONE, DIR_LEFT, SIDE_NONE));
        push_command(make_cmd(OP_CROSSING, 16'd0, 16'd40, 8'd255, TYPE_GARTER, DIR_LEFT, SIDE_NONE));
        push_command(make_cmd(OP_CROSSING, 16'd0, 16'd40, 8'd255, TYPE_GARTER, DIR_RIGHT, SIDE_NONE));
        push_command(make_cmd(OP_SET_POS, 16'd0, 16'd0, 8'd0, TYPE_NONE, DIR_LEFT, SIDE_NONE));
        push_command(make_cmd(OP_CROSSING, 16'd0, 16'h8000, 8'd200, TYPE_LACE, DIR_LEFT, SIDE_NONE));
        push_command(make_cmd(OP_SET_POS, 16'h7FFF, 16'd0, 8'd0, TYPE_NONE, DIR_LEFT, SIDE_NONE));
        push_command(make_cmd(OP_CROSSING, 16'd0, 16'h8001, 8'd255, 3'd7, DIR_RIGHT, SIDE_NONE));
        push_command(make_cmd(OP_CROSSING, 16'd0, 16'h0020, 8'd3, TYPE_NONE, DIR_LEFT, SIDE_NONE));
        push_command(make_cmd(OP_SET_POS, 16'd20, 16'd0, 8'd0, TYPE_NONE, DIR_LEFT, SIDE_NONE));
        push_command(make_cmd(OP_CROSSING, 16'd0, 16'd10, 8'd5, TYPE_K270, DIR_RIGHT, SIDE_NONE));
        push_command(make_cmd(OP_CROSSING, 16'd0, 16'd9, 8'd5, TYPE_KNIT, DIR_LEFT, SIDE_NONE));
        push_command(make_cmd(OP_CROSSING, 16'd0, 16'd2, 8'd5, TYPE_K270, DIR_RIGHT, SIDE_NONE));
        push_command(make_cmd(OP_RESET, 16'd0, 16'd0, 8'd0, TYPE_NONE, DIR_LEFT, SIDE_NONE));
    endtask

    task automatic test_work_window();
        push_command(make_cmd(OP_WORK, 16'd0, 16'd0, 8'd0, TYPE_NONE, DIR_LEFT, SIDE_LEFT));
        push_command(make_cmd(OP_WORK, 16'd0, 16'd0, 8'd0, TYPE_NONE, DIR_RIGHT, 2'd3));
        push_command(make_cmd(OP_RESET, 16'd0, 16'd0, 8'd0, TYPE_NONE, DIR_LEFT, SIDE_NONE));
        push_command(make_cmd(OP_SET_POS, 16'd40, 16'd0, 8'd0, TYPE_NONE, DIR_LEFT, SIDE_NONE));
        push_command(make_cmd(OP_CROSSING, 16'd0, 16'd50, 8'd60, TYPE_K270, DIR_LEFT, SIDE_NONE));
        push_command(make_cmd(OP_WORK, 16'd0, 16'd0, 8'd0, TYPE_NONE, DIR_LEFT, SIDE_NONE));
        push_command(make_cmd(OP_WORK, 16'd0, 16'd0, 8'd0, TYPE_NONE, DIR_LEFT, 2'd3));
        push_command(make_cmd(OP_WORK, 16'd0, 16'd0, 8'd0, TYPE_NONE, DIR_RIGHT, SIDE_LEFT));
        repeat (9)
            push_command(make_cmd(OP_WORK, 16'd0, 16'd0, 8'd0, TYPE_NONE, DIR_LEFT, SIDE_LEFT));
        push_command(make_cmd(OP_RESET, 16'd0, 16'd0, 8'd0, TYPE_NONE, DIR_LEFT, SIDE_NONE));
    endtask

    // The countdown counts up through 255 and wraps to zero, which ends the window.
    task automatic test_overflow_wrap();
        push_command(make_cmd(OP_WORK, 16'd0, 16'd0, 8'd0, TYPE_NONE, DIR_RIGHT, SIDE_NONE));
        repeat (244)
            push_command(make_cmd(OP_WORK, 16'd0, 16'd0, 8'd0, TYPE_NONE, DIR_LEFT, SIDE_RIGHT));
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= 600 && i < 900);
            push_command(random_command());
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_and_position();
        test_crossings();
        test_work_window();
        test_overflow_wrap();
        test_random_traffic();

        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
